>>> rtl/sci_pkg.sv
// shared types, constants and helpers for the sphere collision impulse block
package sci_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int RES_BITS     = 16;
  localparam int ALU_BITS     = 64;
  localparam int CNT_BITS     = 7;
  localparam int MAG_BITS     = WORD_BITS + 1;
  localparam int NRM_BITS     = FRAC_BITS + 2;
  localparam int DIST_BITS    = WORD_BITS + 3;
  localparam int RATIO_BITS   = FRAC_BITS + 1;
  localparam int KEEP_BITS    = 40;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [RES_BITS-1:0]  RESTITUTION_RESET = 16'd62259;
  localparam logic [WORD_BITS-2:0] MASS_ONE          = 31'(1) << FRAC_BITS;

  localparam logic signed [ALU_BITS-1:0] WORD_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [ALU_BITS-1:0] WORD_MIN = -WORD_MAX - 64'sd1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_PAIR = 2'd1,
    CMD_WALL = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RESTITUTION = 1'd0,
    CFG_TOLERANCE   = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WALL,
    ST_EMIT_W,
    ST_PREP,
    ST_SQ,
    ST_SQRT,
    ST_GAP,
    ST_DIVN,
    ST_DOT,
    ST_VN,
    ST_K,
    ST_RA,
    ST_RB,
    ST_KA,
    ST_KB,
    ST_UPD,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;
    logic signed [WORD_BITS-1:0] vel_z;
    logic [WORD_BITS-2:0]        radius;
    logic [WORD_BITS-2:0]        mass;
    axis_t                       wall_axis;
  } in_item_t;

  typedef struct packed {
    logic                        which_particle;
    logic signed [WORD_BITS-1:0] new_vel_x;
    logic signed [WORD_BITS-1:0] new_vel_y;
    logic signed [WORD_BITS-1:0] new_vel_z;
    logic                        impulse_applied;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic [CNT_BITS-1:0] cnt;
    logic [ALU_BITS-1:0] a;
    logic [ALU_BITS-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                done;
    logic [ALU_BITS-1:0] result;
  } alu_rsp_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [ALU_BITS-1:0] x);
    logic signed [WORD_BITS-1:0] r;
    if (x > WORD_MAX) r = WORD_MAX[WORD_BITS-1:0];
    else if (x < WORD_MIN) r = WORD_MIN[WORD_BITS-1:0];
    else r = x[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [MAG_BITS-1:0] x);
    logic [MAG_BITS-1:0] r;
    r = x[MAG_BITS-1] ? MAG_BITS'(-x) : MAG_BITS'(x);
    return r;
  endfunction

endpackage

>>> rtl/sphere_collision_impulse.sv
// top level of the sphere collision impulse block
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one command per transfer:
//   load keeps particle A, pair resolves particle B against A, wall reflects
//   out channel (out_valid/out_ready/out_data) gives results: a pair gives A
//   then B (last on B), a wall item gives one result, load and ignored
//   commands give none
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes restitution
//   and contact tolerance; always ready, write only while idle
// operations:
//   load is stored while idle; a wall item runs one 16-step multiply
//   a pair squares and roots the distance; contact adds the normal divides
//   and dot products, and an impulse adds the scaling and update steps;
//   the unit handles one bit (two for the root) per step
//   in_ready is high only while the sequencer is idle
// reset: sync, clears sequencer, result valid and held-particle valid;
//   restitution returns to 0.95, tolerance to zero, held mass to one
// stall: a finished result waits in the output register; the next input
//   transfer is still taken, and the next result waits for the slot
module sphere_collision_impulse import sci_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_data
);

  logic [RES_BITS-1:0]         restitution;
  logic signed [WORD_BITS-1:0] contact_tolerance;
  alu_req_t                    alu_req;
  alu_rsp_t                    alu_rsp;

  // configuration writes are always accepted and registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution       <= RESTITUTION_RESET;
      contact_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RESTITUTION: restitution       <= cfg_data[RES_BITS-1:0];
        CFG_TOLERANCE:   contact_tolerance <= cfg_data;
        default:         restitution       <= restitution;
      endcase
    end
  end

  // sequencer with particle store and result register
  sci_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .restitution       (restitution),
    .contact_tolerance (contact_tolerance),
    .alu_req           (alu_req),
    .alu_rsp           (alu_rsp)
  );

  // shared multiply / divide / root unit
  sci_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

>>> rtl/sci_alu.sv
// shared iterative unit: shift-add multiply, restoring divide, digit-by-digit square root
module sci_alu import sci_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  alu_op_t             op;
  logic [ALU_BITS-1:0] a;
  logic [ALU_BITS-1:0] b;
  logic [ALU_BITS-1:0] acc;
  logic [ALU_BITS:0]   rem;

  logic [ALU_BITS:0]   rem_sh;
  logic [ALU_BITS:0]   trial;
  logic [ALU_BITS:0]   diff;
  logic                fits;

  always_comb begin
    if (op == ALU_SQRT) begin
      rem_sh = {rem[ALU_BITS-2:0], a[ALU_BITS-1:ALU_BITS-2]};
      trial  = {acc[ALU_BITS-2:0], 2'b01};
    end else begin
      rem_sh = {rem[ALU_BITS-1:0], a[ALU_BITS-1]};
      trial  = {1'b0, b};
    end
    diff = rem_sh - trial;
    fits = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.cnt;
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      a   <= req.a;
      b   <= req.b;
      acc <= '0;
      rem <= '0;
    end else if (busy) begin
      unique case (op)
        ALU_MUL: begin
          if (b[0]) acc <= acc + a;
          a <= a << 1;
          b <= b >> 1;
        end
        ALU_DIV: begin
          rem <= fits ? diff : rem_sh;
          acc <= {acc[ALU_BITS-2:0], fits};
          a   <= a << 1;
        end
        ALU_SQRT: begin
          rem <= fits ? diff : rem_sh;
          acc <= {acc[ALU_BITS-2:0], fits};
          a   <= a << 2;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

>>> rtl/sci_ctrl.sv
// sequencer, particle store, operand registers and result register
module sci_ctrl import sci_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  in_item_t                    in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output out_item_t                   out_data,
  input  logic [RES_BITS-1:0]         restitution,
  input  logic signed [WORD_BITS-1:0] contact_tolerance,
  output alu_req_t                    alu_req,
  input  alu_rsp_t                    alu_rsp
);

  state_t state, state_next;

  logic                        go;
  logic [1:0]                  idx;
  logic                        side;
  logic                        imp;
  logic [1:0]                  s;
  logic [1:0]                  axis_i;

  logic signed [WORD_BITS-1:0] held_pos [3];
  logic signed [WORD_BITS-1:0] held_vel [3];
  logic [WORD_BITS-2:0]        held_radius;
  logic [WORD_BITS-2:0]        held_mass;
  logic                        held_valid;

  logic signed [MAG_BITS-1:0]  d [3];
  logic signed [WORD_BITS-1:0] vb [3];
  logic [WORD_BITS-2:0]        rad_b;
  logic [WORD_BITS-2:0]        mass_b;
  logic [ALU_BITS-1:0]         sum;
  logic [DIST_BITS-1:0]        center_dist;
  logic [NRM_BITS-1:0]         nmag [3];
  logic                        nneg [3];
  logic signed [ALU_BITS-1:0]  dot;
  logic [KEEP_BITS-1:0]        k;
  logic [RATIO_BITS-1:0]       ra;
  logic [RATIO_BITS-1:0]       rb;
  logic [KEEP_BITS-1:0]        ka;
  logic [KEEP_BITS-1:0]        kb;

  logic                        accept;
  logic                        emit_ok;
  logic [MAG_BITS-1:0]         dmag [3];
  logic [MAG_BITS-1:0]         mmax;
  logic signed [MAG_BITS-1:0]  dv;
  logic signed [MAG_BITS-1:0]  vwall;
  logic [WORD_BITS-1:0]        msum;
  logic signed [DIST_BITS+1:0] gap;
  logic                        hit;
  logic signed [ALU_BITS-1:0]  vn;
  logic signed [ALU_BITS-1:0]  sres;
  logic                        sneg;

  // axis slot of a wall item, kept in idx at accept
  function automatic logic [1:0] in_axis_minus_one(input state_t st);
    logic [1:0] r;
    r = (st == ST_WALL) ? idx : 2'd0;
    return r;
  endfunction

  assign accept  = in_valid && in_ready;
  assign emit_ok = !out_valid || out_ready;
  assign axis_i  = 2'(in_axis_minus_one(state));

  always_comb begin
    for (int i = 0; i < 3; i++) dmag[i] = mag_of(d[i]);
    mmax = dmag[0];
    if (dmag[1] > mmax) mmax = dmag[1];
    if (dmag[2] > mmax) mmax = dmag[2];
    dv    = MAG_BITS'(held_vel[idx]) - MAG_BITS'(vb[idx]);
    vwall = MAG_BITS'(vb[axis_i]);
    msum  = {1'b0, held_mass} + {1'b0, mass_b};
    gap   = $signed({2'b00, center_dist})
            - $signed((DIST_BITS+2)'(held_radius) + (DIST_BITS+2)'(rad_b));
    hit   = (gap < (DIST_BITS+2)'(contact_tolerance)) && (center_dist != '0);
    vn    = dot >>> FRAC_BITS;
    unique case (state)
      ST_WALL: sneg = !vwall[MAG_BITS-1];
      ST_DOT:  sneg = dv[MAG_BITS-1] ^ nneg[idx];
      default: sneg = nneg[idx];
    endcase
    sres = sneg ? -$signed(alu_rsp.result) : $signed(alu_rsp.result);
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    alu_req     = '0;
    alu_req.op  = ALU_MUL;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.cmd)
            CMD_LOAD: state_next = ST_IDLE;
            CMD_WALL: state_next = (in_data.wall_axis == AXIS_NONE) ? ST_EMIT_W : ST_WALL;
            CMD_PAIR: state_next = held_valid ? ST_PREP : ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALL: begin
        alu_req.a   = ALU_BITS'(mag_of(vwall));
        alu_req.b   = ALU_BITS'(restitution);
        alu_req.cnt = CNT_BITS'(RES_BITS);
        if (alu_rsp.done) state_next = ST_EMIT_W;
      end
      ST_EMIT_W: if (emit_ok) state_next = ST_IDLE;
      ST_PREP: state_next = ST_SQ;
      ST_SQ: begin
        alu_req.a   = ALU_BITS'(dmag[idx] >> s);
        alu_req.b   = ALU_BITS'(dmag[idx] >> s);
        alu_req.cnt = CNT_BITS'(WORD_BITS - 1);
        if (alu_rsp.done && idx == 2'd2) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        alu_req.op  = ALU_SQRT;
        alu_req.a   = sum;
        alu_req.cnt = CNT_BITS'(ALU_BITS / 2);
        if (alu_rsp.done) state_next = ST_GAP;
      end
      ST_GAP: state_next = hit ? ST_DIVN : ST_EMIT_A;
      ST_DIVN: begin
        alu_req.op  = ALU_DIV;
        alu_req.a   = {dmag[idx], (ALU_BITS - MAG_BITS)'(0)};
        alu_req.b   = ALU_BITS'(center_dist);
        alu_req.cnt = CNT_BITS'(MAG_BITS + FRAC_BITS);
        if (alu_rsp.done && idx == 2'd2) state_next = ST_DOT;
      end
      ST_DOT: begin
        alu_req.a   = ALU_BITS'(mag_of(dv));
        alu_req.b   = ALU_BITS'(nmag[idx]);
        alu_req.cnt = CNT_BITS'(NRM_BITS);
        if (alu_rsp.done && idx == 2'd2) state_next = ST_VN;
      end
      ST_VN: state_next = (vn < 0 && msum != '0) ? ST_K : ST_EMIT_A;
      ST_K: begin
        alu_req.a   = ALU_BITS'(-vn);
        alu_req.b   = ALU_BITS'({1'b1, restitution});
        alu_req.cnt = CNT_BITS'(RES_BITS + 1);
        if (alu_rsp.done) state_next = ST_RA;
      end
      ST_RA: begin
        alu_req.op  = ALU_DIV;
        alu_req.a   = {mass_b, (ALU_BITS - WORD_BITS + 1)'(0)};
        alu_req.b   = ALU_BITS'(msum);
        alu_req.cnt = CNT_BITS'(WORD_BITS - 1 + FRAC_BITS);
        if (alu_rsp.done) state_next = ST_RB;
      end
      ST_RB: begin
        alu_req.op  = ALU_DIV;
        alu_req.a   = {held_mass, (ALU_BITS - WORD_BITS + 1)'(0)};
        alu_req.b   = ALU_BITS'(msum);
        alu_req.cnt = CNT_BITS'(WORD_BITS - 1 + FRAC_BITS);
        if (alu_rsp.done) state_next = ST_KA;
      end
      ST_KA: begin
        alu_req.a   = ALU_BITS'(k);
        alu_req.b   = ALU_BITS'(ra);
        alu_req.cnt = CNT_BITS'(RATIO_BITS);
        if (alu_rsp.done) state_next = ST_KB;
      end
      ST_KB: begin
        alu_req.a   = ALU_BITS'(k);
        alu_req.b   = ALU_BITS'(rb);
        alu_req.cnt = CNT_BITS'(RATIO_BITS);
        if (alu_rsp.done) state_next = ST_UPD;
      end
      ST_UPD: begin
        alu_req.a   = ALU_BITS'(side ? kb : ka);
        alu_req.b   = ALU_BITS'(nmag[idx]);
        alu_req.cnt = CNT_BITS'(NRM_BITS);
        if (alu_rsp.done && side && idx == 2'd2) state_next = ST_EMIT_A;
      end
      ST_EMIT_A: if (emit_ok) state_next = ST_EMIT_B;
      ST_EMIT_B: if (emit_ok) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    // start the unit whenever an arithmetic state has no operation in flight
    unique case (state)
      ST_WALL, ST_SQ, ST_SQRT, ST_DIVN, ST_DOT, ST_K, ST_RA, ST_RB, ST_KA, ST_KB,
      ST_UPD: alu_req.start = !go;
      default: alu_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      go         <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (alu_req.start) go <= 1'b1;
      else if (alu_rsp.done) go <= 1'b0;
      if (accept && in_data.cmd == CMD_LOAD) held_valid <= 1'b1;
      if ((state == ST_EMIT_W || state == ST_EMIT_A || state == ST_EMIT_B) && emit_ok)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // particle store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held_pos[i] <= '0;
        held_vel[i] <= '0;
      end
      held_radius <= '0;
      held_mass   <= MASS_ONE;
    end else begin
      if (accept && in_data.cmd == CMD_LOAD) begin
        held_pos[0] <= in_data.pos_x;
        held_pos[1] <= in_data.pos_y;
        held_pos[2] <= in_data.pos_z;
        held_vel[0] <= in_data.vel_x;
        held_vel[1] <= in_data.vel_y;
        held_vel[2] <= in_data.vel_z;
        held_radius <= in_data.radius;
        held_mass   <= in_data.mass;
      end
      if (state == ST_UPD && alu_rsp.done && !side)
        held_vel[idx] <= sat_word(ALU_BITS'(held_vel[idx]) + (sres >>> FRAC_BITS));
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      d[0]   <= MAG_BITS'(held_pos[0]) - MAG_BITS'(in_data.pos_x);
      d[1]   <= MAG_BITS'(held_pos[1]) - MAG_BITS'(in_data.pos_y);
      d[2]   <= MAG_BITS'(held_pos[2]) - MAG_BITS'(in_data.pos_z);
      vb[0]  <= in_data.vel_x;
      vb[1]  <= in_data.vel_y;
      vb[2]  <= in_data.vel_z;
      rad_b  <= in_data.radius;
      mass_b <= in_data.mass;
      imp    <= 1'b0;
      idx    <= 2'(in_data.wall_axis - AXIS_X);
    end
    unique case (state)
      ST_WALL: if (alu_rsp.done) begin
        vb[idx] <= sat_word(sres >>> RES_BITS);
        imp     <= 1'b1;
      end
      ST_PREP: begin
        s    <= mmax[MAG_BITS-1] ? 2'd2 : (mmax[MAG_BITS-2] ? 2'd1 : 2'd0);
        sum  <= '0;
        idx  <= 2'd0;
        dot  <= '0;
        side <= 1'b0;
      end
      ST_SQ: if (alu_rsp.done) begin
        sum <= sum + alu_rsp.result;
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
      ST_SQRT: if (alu_rsp.done)
        center_dist <= DIST_BITS'(alu_rsp.result[WORD_BITS-1:0]) << s;
      ST_DIVN: if (alu_rsp.done) begin
        nmag[idx] <= alu_rsp.result[NRM_BITS-1:0];
        nneg[idx] <= d[idx][MAG_BITS-1];
        idx       <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
      ST_DOT: if (alu_rsp.done) begin
        dot <= dot + sres;
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
      ST_K:  if (alu_rsp.done) k  <= KEEP_BITS'(alu_rsp.result >> RES_BITS);
      ST_RA: if (alu_rsp.done) ra <= alu_rsp.result[RATIO_BITS-1:0];
      ST_RB: if (alu_rsp.done) rb <= alu_rsp.result[RATIO_BITS-1:0];
      ST_KA: if (alu_rsp.done) ka <= KEEP_BITS'(alu_rsp.result >> FRAC_BITS);
      ST_KB: if (alu_rsp.done) kb <= KEEP_BITS'(alu_rsp.result >> FRAC_BITS);
      ST_UPD: if (alu_rsp.done) begin
        if (side) vb[idx] <= sat_word(ALU_BITS'(vb[idx]) - (sres >>> FRAC_BITS));
        if (idx == 2'd2) begin
          idx  <= 2'd0;
          side <= 1'b1;
          if (side) imp <= 1'b1;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_ok) begin
      unique case (state)
        ST_EMIT_W, ST_EMIT_B: begin
          out_data.which_particle  <= (state == ST_EMIT_B);
          out_data.new_vel_x       <= vb[0];
          out_data.new_vel_y       <= vb[1];
          out_data.new_vel_z       <= vb[2];
          out_data.impulse_applied <= imp;
          out_data.last            <= 1'b1;
        end
        ST_EMIT_A: begin
          out_data.which_particle  <= 1'b0;
          out_data.new_vel_x       <= held_vel[0];
          out_data.new_vel_y       <= held_vel[1];
          out_data.new_vel_z       <= held_vel[2];
          out_data.impulse_applied <= imp;
          out_data.last            <= 1'b0;
        end
        default: begin
          out_data <= out_data;
        end
      endcase
    end
  end

endmodule

>>> rtl/sci_checker.sv
// port-level checks for the sphere collision impulse block
module sci_assertions import sci_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_b_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.which_particle |-> out_data.last)
    else $error("particle B result not marked last");

  a_wall_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == CMD_WALL |=> !in_ready)
    else $error("ready right after a wall transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sphere_collision_impulse sci_assertions u_sci_assertions (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
